### design/rrts_pkg.sv
// types, codes and frame-word table shared by the round-robin task scheduler
package rrts_pkg;

	localparam int MAX_TASKS_DEF = 16;

	localparam logic [1:0] CMD_CREATE_K = 2'd0;
	localparam logic [1:0] CMD_CREATE_U = 2'd1;
	localparam logic [1:0] CMD_TICK     = 2'd2;
	localparam logic [1:0] CMD_EXIT     = 2'd3;

	localparam logic [1:0] KIND_FRAME  = 2'd0;
	localparam logic [1:0] KIND_DONE   = 2'd1;
	localparam logic [1:0] KIND_SWITCH = 2'd2;
	localparam logic [1:0] KIND_HALT   = 2'd3;

	localparam logic [1:0] ST_DEAD    = 2'd0;
	localparam logic [1:0] ST_READY   = 2'd1;
	localparam logic [1:0] ST_RUNNING = 2'd2;

	localparam logic [31:0] SEL_KCODE   = 32'h0000_0008;
	localparam logic [31:0] SEL_KDATA   = 32'h0000_0010;
	localparam logic [31:0] SEL_UCODE   = 32'h0000_001B;
	localparam logic [31:0] SEL_UDATA   = 32'h0000_0023;
	localparam logic [31:0] EFLAGS_INIT = 32'h0000_0202;

	// frame word positions, user layout; kernel frames start at FJ_FLAGS
	localparam logic [4:0] FJ_SS    = 5'd0;
	localparam logic [4:0] FJ_USP   = 5'd1;
	localparam logic [4:0] FJ_FLAGS = 5'd2;
	localparam logic [4:0] FJ_CS    = 5'd3;
	localparam logic [4:0] FJ_EIP   = 5'd4;
	localparam logic [4:0] FJ_DS0   = 5'd15;
	localparam logic [4:0] FJ_LAST  = 5'd18;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] entry_addr;
		logic [31:0] kstack_top;
		logic [31:0] ustack_top;
		logic [31:0] cur_sp;
	} rrts_in_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] write_addr;
		logic [31:0] write_data;
		logic [31:0] new_pid;
		logic [31:0] resume_sp;
		logic        load_kstack;
		logic [31:0] kstack_value;
		logic        last;
	} rrts_out_t;

	typedef struct packed {
		logic [31:0] pid;
		logic [1:0]  status;
		logic [31:0] saved_sp;
		logic [31:0] kstack;
	} rrts_rec_t;

	typedef struct packed {
		logic start;
		logic user;
	} rrts_frm_ctl_t;

	typedef struct packed {
		logic        valid;
		logic        last;
		logic [31:0] addr;
		logic [31:0] data;
	} rrts_frm_word_t;

	function automatic logic [31:0] frame_word(input logic user, input logic [4:0] j,
			input logic [31:0] entry, input logic [31:0] utop);
		logic [31:0] w;
		begin
			w = '0;
			if (j >= FJ_DS0) begin
				w = user ? SEL_UDATA : SEL_KDATA;
			end else begin
				case (j)
					FJ_SS:    w = SEL_UDATA;
					FJ_USP:   w = utop;
					FJ_FLAGS: w = EFLAGS_INIT;
					FJ_CS:    w = user ? SEL_UCODE : SEL_KCODE;
					FJ_EIP:   w = entry;
					default:  w = '0;
				endcase
			end
			return w;
		end
	endfunction

	function automatic rrts_out_t mk_res(input logic [1:0] kind, input logic [31:0] addr,
			input logic [31:0] data, input logic [31:0] pid, input logic [31:0] sp,
			input logic load, input logic [31:0] kval, input logic last);
		rrts_out_t r;
		begin
			r.kind         = kind;
			r.write_addr   = addr;
			r.write_data   = data;
			r.new_pid      = pid;
			r.resume_sp    = sp;
			r.load_kstack  = load;
			r.kstack_value = kval;
			r.last         = last;
			return r;
		end
	endfunction

endpackage

### design/rrts_ram.sv
// generic single-write, registered-read ram
module rrts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### design/rrts_frame.sv
// initial stack frame generator, one word per cycle with a shared address decrement
module rrts_frame
	import rrts_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  rrts_frm_ctl_t  ctl,
	input  logic [31:0]    entry,
	input  logic [31:0]    ktop,
	input  logic [31:0]    utop,
	output rrts_frm_word_t word,
	output logic [31:0]    sp
);

	logic        run_q;
	logic        user_q;
	logic [4:0]  j_q;
	logic [31:0] addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			user_q <= 1'b0;
			j_q    <= FJ_SS;
		end else if (ctl.start) begin
			run_q  <= 1'b1;
			user_q <= ctl.user;
			j_q    <= ctl.user ? FJ_SS : FJ_FLAGS;
		end else if (run_q) begin
			if (j_q == FJ_LAST) begin
				run_q <= 1'b0;
			end else begin
				j_q <= j_q + 5'd1;
			end
		end
	end

	// address of the word on show; holds the final sp after the last word
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			addr_q <= ktop - 32'd4;
		end else if (run_q && j_q != FJ_LAST) begin
			addr_q <= addr_q - 32'd4;
		end
	end

	assign word.valid = run_q;
	assign word.last  = (j_q == FJ_LAST);
	assign word.addr  = addr_q;
	assign word.data  = frame_word(user_q, j_q, entry, utop);
	assign sp         = addr_q;

endmodule

### design/round_robin_task_scheduler_unit.sv
// round-robin task scheduler: task table, ring walk and create sequencer
//
// usage: drive req and raise start; the word is taken at a clock edge with start high
// and busy low. results come out on rsp, each valid for exactly one cycle while strobe
// is high; the receiver cannot stall, so every strobed word must be taken then.
// rsp.last marks the final result word of a command.
// create: first free slot is found by a scan of the free flags, one slot per cycle,
// then 17 (kernel) or 19 (user) frame writes, one per cycle, then the record and
// link writes in S_CWR and S_CW2, then a create-done word.
// a full table or a halted block answers with one word the cycle after start.
// tick / exit: one table read, then the ring walk reads one slot at a time through
// the registered table ram, passing S_WAIT before S_RCUR and before each S_WALK;
// the switch or halt word is strobed from S_WALK.
// reset clears the table to one running task (pid 1) in slot 0; per-slot valid bits
// make unwritten table entries read as their reset value, so no clearing pass runs.
module round_robin_task_scheduler_unit
	import rrts_pkg::*;
#(
	parameter int MAX_TASKS = MAX_TASKS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  rrts_in_t  req,
	output rrts_out_t rsp,
	output logic      strobe
);

	localparam int SW = $clog2(MAX_TASKS);
	localparam int LW = $clog2(MAX_TASKS + 1);
	localparam int TW = $clog2(MAX_TASKS + 2);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_SCAN  = 8'b0000_0010,
		S_FRAME = 8'b0000_0100,
		S_CWR   = 8'b0000_1000,
		S_CW2   = 8'b0001_0000,
		S_WAIT  = 8'b0010_0000,
		S_RCUR  = 8'b0100_0000,
		S_WALK  = 8'b1000_0000
	} state_t;

	state_t         state_q, ret_q;
	rrts_in_t       in_q;
	rrts_out_t      res_q;
	logic           strobe_q;
	logic [SW-1:0]  cur_q, rd_idx_q, idx_q, slot_q;
	logic [31:0]    pid_q;
	logic [LW-1:0]  live_q;
	logic           halted_q;
	logic [TW-1:0]  steps_q;
	logic [MAX_TASKS-1:0] nu_q, rvld_q, lvld_q;
	rrts_rec_t      cur_rec_q;
	logic           rvld_s1, lvld_s1, rzero_s1;

	logic           rec_we, lnk_we;
	logic [SW-1:0]  rec_waddr, lnk_waddr, lnk_wdata, lnk_raw, lnk_rd;
	rrts_rec_t      rec_wdata, rec_raw, rec_rd, rec_dflt;

	rrts_frm_ctl_t  frm_ctl;
	rrts_frm_word_t frm_word;
	logic [31:0]    frm_sp;

	logic           is_tick, walk_ready, stop_tick, stop_exit;
	logic [TW-1:0]  steps_inc;

	rrts_ram #(.WIDTH($bits(rrts_rec_t)), .DEPTH(MAX_TASKS)) u_rec_ram (
		.clk   (clk),
		.we    (rec_we),
		.waddr (rec_waddr),
		.wdata (rec_wdata),
		.raddr (rd_idx_q),
		.rdata (rec_raw)
	);

	rrts_ram #(.WIDTH(SW), .DEPTH(MAX_TASKS)) u_lnk_ram (
		.clk   (clk),
		.we    (lnk_we),
		.waddr (lnk_waddr),
		.wdata (lnk_wdata),
		.raddr (rd_idx_q),
		.rdata (lnk_raw)
	);

	rrts_frame u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (frm_ctl),
		.entry  (in_q.entry_addr),
		.ktop   (in_q.kstack_top),
		.utop   (in_q.ustack_top),
		.word   (frm_word),
		.sp     (frm_sp)
	);

	// unwritten entries read as reset values
	always_comb begin
		rec_dflt = '0;
		if (rzero_s1) begin
			rec_dflt.pid    = 32'd1;
			rec_dflt.status = ST_RUNNING;
		end
	end

	assign rec_rd     = rvld_s1 ? rec_raw : rec_dflt;
	assign lnk_rd     = lvld_s1 ? lnk_raw : '0;
	assign is_tick    = (in_q.command == CMD_TICK);
	assign walk_ready = (rec_rd.status == ST_READY);
	assign steps_inc  = steps_q + TW'(1);
	assign stop_tick  = (lnk_rd == cur_q) || (steps_inc > TW'(MAX_TASKS));
	assign stop_exit  = (rd_idx_q == cur_q) || (steps_q > TW'(MAX_TASKS));

	assign frm_ctl.start = (state_q == S_SCAN) && nu_q[idx_q];
	assign frm_ctl.user  = (in_q.command == CMD_CREATE_U);

	always_comb begin
		rec_we    = 1'b0;
		rec_waddr = rd_idx_q;
		rec_wdata = rec_rd;
		lnk_we    = 1'b0;
		lnk_waddr = slot_q;
		lnk_wdata = lnk_rd;
		case (state_q)
			S_RCUR: begin
				rec_we             = 1'b1;
				rec_waddr          = cur_q;
				rec_wdata.status   = is_tick ? ST_READY : ST_DEAD;
				rec_wdata.saved_sp = in_q.cur_sp;
			end
			S_WALK: begin
				if (walk_ready) begin
					rec_we           = 1'b1;
					rec_wdata.status = ST_RUNNING;
				end else if (is_tick && stop_tick) begin
					rec_we           = 1'b1;
					rec_waddr        = cur_q;
					rec_wdata        = cur_rec_q;
					rec_wdata.status = ST_RUNNING;
				end
			end
			S_CWR: begin
				rec_we             = 1'b1;
				rec_waddr          = slot_q;
				rec_wdata.pid      = pid_q;
				rec_wdata.status   = ST_READY;
				rec_wdata.saved_sp = frm_sp;
				rec_wdata.kstack   = frm_ctl.user ? in_q.kstack_top : 32'd0;
				lnk_we             = 1'b1;
			end
			S_CW2: begin
				lnk_we    = 1'b1;
				lnk_waddr = cur_q;
				lnk_wdata = slot_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ret_q     <= S_IDLE;
			strobe_q  <= 1'b0;
			cur_q     <= '0;
			pid_q     <= 32'd2;
			live_q    <= LW'(1);
			halted_q  <= 1'b0;
			nu_q      <= {{(MAX_TASKS-1){1'b1}}, 1'b0};
			rvld_q    <= '0;
			lvld_q    <= '0;
			rd_idx_q  <= '0;
			idx_q     <= '0;
			slot_q    <= '0;
			steps_q   <= '0;
			rvld_s1   <= 1'b0;
			lvld_s1   <= 1'b0;
			rzero_s1  <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			rvld_s1  <= rvld_q[rd_idx_q];
			lvld_s1  <= lvld_q[rd_idx_q];
			rzero_s1 <= (rd_idx_q == '0);
			if (rec_we) begin
				rvld_q[rec_waddr] <= 1'b1;
				nu_q[rec_waddr]   <= (rec_wdata.status == ST_DEAD) && (rec_wdata.pid == '0);
			end
			if (lnk_we) begin
				lvld_q[lnk_waddr] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						rd_idx_q <= cur_q;
						if (halted_q) begin
							strobe_q <= 1'b1;
						end else if (req.command == CMD_CREATE_K ||
								req.command == CMD_CREATE_U) begin
							if (live_q >= LW'(MAX_TASKS)) begin
								strobe_q <= 1'b1;
							end else begin
								idx_q   <= '0;
								state_q <= S_SCAN;
							end
						end else begin
							state_q <= S_WAIT;
							ret_q   <= S_RCUR;
						end
					end
				end
				S_SCAN: begin
					if (nu_q[idx_q]) begin
						slot_q  <= idx_q;
						state_q <= S_FRAME;
					end else if (idx_q == SW'(MAX_TASKS - 1)) begin
						strobe_q <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						idx_q <= idx_q + SW'(1);
					end
				end
				S_FRAME: begin
					if (frm_word.valid) begin
						strobe_q <= 1'b1;
						if (frm_word.last) begin
							state_q <= S_CWR;
						end
					end
				end
				S_CWR: begin
					state_q <= S_CW2;
				end
				S_CW2: begin
					strobe_q <= 1'b1;
					pid_q    <= pid_q + 32'd1;
					live_q   <= live_q + LW'(1);
					state_q  <= S_IDLE;
				end
				S_WAIT: begin
					state_q <= ret_q;
				end
				S_RCUR: begin
					cur_rec_q <= rec_wdata;
					if (!is_tick && live_q != '0) begin
						live_q <= live_q - LW'(1);
					end
					steps_q  <= '0;
					rd_idx_q <= lnk_rd;
					state_q  <= S_WAIT;
					ret_q    <= S_WALK;
				end
				S_WALK: begin
					if (walk_ready) begin
						cur_q    <= rd_idx_q;
						strobe_q <= 1'b1;
						state_q  <= S_IDLE;
					end else if (is_tick ? stop_tick : stop_exit) begin
						if (!is_tick) begin
							halted_q <= 1'b1;
						end
						strobe_q <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						rd_idx_q <= lnk_rd;
						steps_q  <= steps_inc;
						state_q  <= S_WAIT;
						ret_q    <= S_WALK;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result word register
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					in_q <= req;
					if (halted_q) begin
						res_q <= mk_res(KIND_HALT, '0, '0, '0, '0, 1'b0, '0, 1'b1);
					end else begin
						res_q <= mk_res(KIND_DONE, '0, '0, '0, '0, 1'b0, '0, 1'b1);
					end
				end
			end
			S_SCAN: begin
				res_q <= mk_res(KIND_DONE, '0, '0, '0, '0, 1'b0, '0, 1'b1);
			end
			S_FRAME: begin
				res_q <= mk_res(KIND_FRAME, frm_word.addr, frm_word.data, '0, '0, 1'b0, '0,
					1'b0);
			end
			S_CW2: begin
				res_q <= mk_res(KIND_DONE, '0, '0, pid_q, frm_sp, 1'b0, '0, 1'b1);
			end
			S_WALK: begin
				if (walk_ready) begin
					res_q <= mk_res(KIND_SWITCH, '0, '0, '0, rec_rd.saved_sp,
						rec_rd.kstack != '0, rec_rd.kstack, 1'b1);
				end else if (is_tick) begin
					res_q <= mk_res(KIND_SWITCH, '0, '0, '0, in_q.cur_sp, 1'b0, '0, 1'b1);
				end else begin
					res_q <= mk_res(KIND_HALT, '0, '0, '0, '0, 1'b0, '0, 1'b1);
				end
			end
			default: begin
			end
		endcase
	end

	assign busy   = (state_q != S_IDLE);
	assign rsp    = res_q;
	assign strobe = strobe_q;

endmodule

### design/rrts_checker.sv
// port-level checks for the round-robin task scheduler, bound to the top level
module rrts_checker
	import rrts_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input rrts_out_t rsp,
	input logic      strobe
);

	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (rsp.last == (rsp.kind != KIND_FRAME)))
		else $error("last flag does not match result kind");

	a_nonframe_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && rsp.kind != KIND_FRAME) |-> (rsp.write_addr == '0 && rsp.write_data == '0))
		else $error("write fields set on a non-write word");

	a_frame_step: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && rsp.kind == KIND_FRAME && $past(strobe) && $past(rsp.kind) == KIND_FRAME)
		|-> (rsp.write_addr == $past(rsp.write_addr) - 32'd4))
		else $error("frame words not on descending addresses");

	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a start");

endmodule

bind round_robin_task_scheduler_unit rrts_checker u_rrts_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.rsp    (rsp),
	.strobe (strobe)
);
